/* rtl/mpe_zone_rpn_tracker_top_defines.svh */
// ----------------------------------------------------------------------------
// MPE zone RPN tracker: assertion macros
// Shared concurrent assertion forms used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MPE_ZONE_RPN_TRACKER_TOP_DEFINES_SVH
`define MPE_ZONE_RPN_TRACKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MZRT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MZRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mzrt_pkg.sv */
// ----------------------------------------------------------------------------
// MPE zone RPN tracker package
// Transaction types, decode result type and protocol constants.
// ----------------------------------------------------------------------------
package mzrt_pkg;

  // Zone boundary values that mean the zone is off.
  localparam logic [3:0] LOWER_OFF = 4'd0;
  localparam logic [3:0] UPPER_OFF = 4'd15;

  // Channels that act as zone masters.
  localparam logic [3:0] LOWER_MASTER = 4'd0;
  localparam logic [3:0] UPPER_MASTER = 4'd15;

  // Push-aside limits.
  localparam logic [3:0] LOWER_FULL = 4'd14;
  localparam logic [3:0] UPPER_FULL = 4'd1;

  // Registered parameter numbers.
  localparam logic [6:0] RPN_MSB_ZERO = 7'd0;
  localparam logic [6:0] RPN_LSB_BEND = 7'd0;
  localparam logic [6:0] RPN_LSB_MCM  = 7'd6;
  localparam logic [6:0] MCM_LIMIT    = 7'd16;

  // Default bend ranges after a zone is configured.
  localparam logic [6:0] MAIN_DEFAULT   = 7'd2;
  localparam logic [6:0] MEMBER_DEFAULT = 7'd48;

  // Report targets and kinds.
  localparam logic [4:0] TARGET_LOWER = 5'd16;
  localparam logic [4:0] TARGET_UPPER = 5'd17;
  localparam logic       KIND_MAIN    = 1'b0;
  localparam logic       KIND_MEMBER  = 1'b1;

  // Report counts per event.
  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] param_msb;
    logic [6:0] param_lsb;
    logic [6:0] entry_value;
  } mzrt_in_t;

  typedef struct packed {
    logic [4:0] report_target;
    logic       report_kind;
    logic [6:0] report_range;
    logic       last_of_run;
  } mzrt_out_t;

  // Everything the decoder hands back for one event.
  typedef struct packed {
    logic [1:0] count;
    mzrt_out_t  first;
    mzrt_out_t  second;
    logic [3:0] lower_last;
    logic [3:0] upper_last;
  } mzrt_dec_t;

endpackage

/* rtl/mzrt_decode.sv */
// ----------------------------------------------------------------------------
// MPE zone RPN tracker: event decoder
// Turns one data-entry event and the current zone bounds into reports and
// the next zone bounds.
// ----------------------------------------------------------------------------
module mzrt_decode
  import mzrt_pkg::*;
(
  input  mzrt_in_t   item,
  input  logic [3:0] lower_last,
  input  logic [3:0] upper_last,
  output mzrt_dec_t  dec
);

  logic       lower_on;
  logic       upper_on;
  logic       is_bend;
  logic       is_mcm;
  logic       in_lower;
  logic       in_upper;
  logic       master;
  logic [3:0] val4;
  logic [3:0] new_upper;
  mzrt_out_t  bend_rpt;

  assign lower_on = (lower_last != LOWER_OFF);
  assign upper_on = (upper_last != UPPER_OFF);
  assign is_bend  = (item.param_msb == RPN_MSB_ZERO) && (item.param_lsb == RPN_LSB_BEND);
  assign is_mcm   = (item.param_msb == RPN_MSB_ZERO) && (item.param_lsb == RPN_LSB_MCM) &&
                    (item.entry_value < MCM_LIMIT);
  assign val4      = item.entry_value[3:0];
  assign new_upper = UPPER_OFF - val4;

  // Zone membership for a bend range update; the lower zone wins a tie.
  assign in_lower = lower_on && (lower_last >= item.chan);
  assign in_upper = !in_lower && upper_on && (upper_last <= item.chan);
  assign master   = (lower_on && (item.chan == LOWER_MASTER)) ||
                    (upper_on && (item.chan == UPPER_MASTER));

  // Single bend range report.
  always_comb begin
    bend_rpt.report_range = item.entry_value;
    bend_rpt.last_of_run  = 1'b1;
    if (in_lower) begin
      bend_rpt.report_target = TARGET_LOWER;
      bend_rpt.report_kind   = master ? KIND_MAIN : KIND_MEMBER;
    end else if (in_upper) begin
      bend_rpt.report_target = TARGET_UPPER;
      bend_rpt.report_kind   = master ? KIND_MAIN : KIND_MEMBER;
    end else begin
      bend_rpt.report_target = {1'b0, item.chan};
      bend_rpt.report_kind   = KIND_MAIN;
    end
  end

  // Event decode and zone reshaping.
  always_comb begin
    dec.count      = COUNT_NONE;
    dec.first      = bend_rpt;
    dec.second     = bend_rpt;
    dec.lower_last = lower_last;
    dec.upper_last = upper_last;
    if (is_bend) begin
      dec.count = COUNT_ONE;
    end else if (is_mcm && lower_on && (item.chan == LOWER_MASTER)) begin
      // Lower zone reshaped, then the upper zone is pushed aside.
      dec.lower_last = val4;
      if (val4 >= LOWER_FULL) begin
        dec.upper_last = UPPER_OFF;
      end else if ((val4 != LOWER_OFF) && (upper_last <= val4)) begin
        dec.upper_last = val4 + 4'd1;
      end
      dec.count                = (val4 != 4'd0) ? COUNT_TWO : COUNT_NONE;
      dec.first.report_target  = TARGET_LOWER;
      dec.second.report_target = TARGET_LOWER;
    end else if (is_mcm && upper_on && (item.chan == UPPER_MASTER)) begin
      // Upper zone reshaped, then the lower zone is pushed aside.
      dec.upper_last = new_upper;
      if (new_upper <= UPPER_FULL) begin
        dec.lower_last = LOWER_OFF;
      end else if ((new_upper != UPPER_OFF) && (lower_last >= new_upper)) begin
        dec.lower_last = new_upper - 4'd1;
      end
      dec.count                = (val4 != 4'd0) ? COUNT_TWO : COUNT_NONE;
      dec.first.report_target  = TARGET_UPPER;
      dec.second.report_target = TARGET_UPPER;
    end
    if (!is_bend) begin
      dec.first.report_kind   = KIND_MAIN;
      dec.first.report_range  = MAIN_DEFAULT;
      dec.first.last_of_run   = 1'b0;
      dec.second.report_kind  = KIND_MEMBER;
      dec.second.report_range = MEMBER_DEFAULT;
      dec.second.last_of_run  = 1'b1;
    end
  end

endmodule

/* rtl/mpe_zone_rpn_tracker_top.sv */
// Path: an accepted event is held in the input register and retires into the output
// register once no report is pending and the presented report is taken or absent.
// Throughput: one event per cycle while the receiver takes every report and each
// event yields at most one report; after an event that yields two reports, the next
// event waits until the pending second report moves into the single output register.
// Reset: zones off (lower bound 0, upper bound 15), input and output stages empty.
// ----------------------------------------------------------------------------
// MPE zone RPN tracker top level
// Tracks MPE zone bounds from data-entry events and emits bend range reports.
// ----------------------------------------------------------------------------
`include "mpe_zone_rpn_tracker_top_defines.svh"

module mpe_zone_rpn_tracker_top
  import mzrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  mzrt_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output mzrt_out_t result
);

  logic       item_vld;
  mzrt_in_t   item_q;
  logic [3:0] lower_last;
  logic [3:0] upper_last;
  logic       out_vld;
  mzrt_out_t  out_data;
  logic       pend_vld;
  mzrt_out_t  pend_data;
  mzrt_dec_t  dec;
  logic       out_take;
  logic       retire;

  assign out_take     = out_vld && result_ready;
  assign retire       = item_vld && !pend_vld && (!out_vld || result_ready);
  assign item_ready   = !item_vld || retire;
  assign result_valid = out_vld;
  assign result       = out_data;

  mzrt_decode u_decode (
    .item       (item_q),
    .lower_last (lower_last),
    .upper_last (upper_last),
    .dec        (dec)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item_ready) begin
      item_vld <= item_valid;
    end
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Zone bounds advance when the held event is retired.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_last <= LOWER_OFF;
      upper_last <= UPPER_OFF;
    end else if (retire) begin
      lower_last <= dec.lower_last;
      upper_last <= dec.upper_last;
    end
  end

  // Output register with one pending slot for the second report.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else if (retire) begin
      out_vld  <= (dec.count != COUNT_NONE) || (out_vld && !result_ready);
      pend_vld <= (dec.count == COUNT_TWO);
    end else if (out_take) begin
      out_vld  <= pend_vld;
      pend_vld <= 1'b0;
    end
    if (retire && (dec.count != COUNT_NONE)) begin
      out_data  <= dec.first;
      pend_data <= dec.second;
    end else if (out_take && pend_vld) begin
      out_data <= pend_data;
    end
  end

  `MZRT_ASSERT_IMPLY(a_pend_behind_out, clk, rst, pend_vld, out_vld,
    "pending report without a presented report")
  `MZRT_ASSERT_IMPLY(a_first_has_partner, clk, rst, out_vld && !out_data.last_of_run,
    pend_vld, "first of two reports presented without its partner")
  `MZRT_ASSERT_NEXT(a_pair_loaded, clk, rst, retire && (dec.count == COUNT_TWO),
    out_vld && pend_vld && !out_data.last_of_run, "report pair not loaded")
  `MZRT_ASSERT_IMPLY(a_zones_disjoint, clk, rst,
    (lower_last != LOWER_OFF) && (upper_last != UPPER_OFF), upper_last > lower_last,
    "active zones overlap")

endmodule

/* bench/tb_mpe_zone_rpn_tracker_top.sv */
// ----------------------------------------------------------------------------
// MPE zone RPN tracker testbench
// Drives data-entry transactions into the tracker with random idle and stall
// cycles on both sides. Every accepted event is run through a local model of
// the zone bounds and bend ranges. Each report is checked field by field in
// order against the oldest expected report.
// ----------------------------------------------------------------------------
module tb_mpe_zone_rpn_tracker_top;
  import mzrt_pkg::*;

  localparam int ITEM_GOAL    = 800;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  // One row of the directed table. A negative typed count means the model
  // decides the expected reports.
  typedef struct {
    mzrt_in_t  ev;
    int        n_typed;
    mzrt_out_t rep;
  } entry_row_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  mzrt_in_t  item;
  logic      result_valid;
  logic      result_ready;
  mzrt_out_t result;

  // Local copy of the tracker state.
  logic [3:0] lower_last;
  logic [3:0] upper_last;
  logic [6:0] zone_range [4];
  logic [6:0] chan_range [16];

  mzrt_out_t  pending_reports [$];
  mzrt_out_t  want;
  entry_row_t directed_rows [$];
  bit         no_gaps;
  int         events_sent;
  int         range_events;
  int         reports_seen;
  int         mismatches;
  int         idle_cycles;

  mpe_zone_rpn_tracker_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Apply one data-entry event to the local state and return its reports.
  function automatic int apply_data_entry(input mzrt_in_t ev, output mzrt_out_t r0,
                                          output mzrt_out_t r1);
    logic       lower_on;
    logic       upper_on;
    logic       in_zone;
    logic       upper_sel;
    logic       kind_bit;
    logic [4:0] target;
    lower_on  = (lower_last != LOWER_OFF);
    upper_on  = (upper_last != UPPER_OFF);
    in_zone   = 1'b1;
    upper_sel = 1'b0;
    kind_bit  = KIND_MAIN;
    r0        = '0;
    r1        = '0;
    if (ev.param_msb == RPN_MSB_ZERO && ev.param_lsb == RPN_LSB_BEND) begin
      // Bend range: the zone the channel falls in, else the channel itself.
      if (lower_on && lower_last >= ev.chan) begin
        upper_sel = 1'b0;
      end else if (upper_on && upper_last <= ev.chan) begin
        upper_sel = 1'b1;
      end else begin
        in_zone = 1'b0;
      end
      if (in_zone) begin
        kind_bit = ((lower_on && ev.chan == LOWER_MASTER) ||
                    (upper_on && ev.chan == UPPER_MASTER)) ? KIND_MAIN : KIND_MEMBER;
        zone_range[{upper_sel, kind_bit}] = ev.entry_value;
        target = upper_sel ? TARGET_UPPER : TARGET_LOWER;
      end else begin
        chan_range[ev.chan] = ev.entry_value;
        target = {1'b0, ev.chan};
      end
      r0.report_target = target;
      r0.report_kind   = kind_bit;
      r0.report_range  = ev.entry_value;
      r0.last_of_run   = 1'b1;
      return 1;
    end
    if (ev.param_msb == RPN_MSB_ZERO && ev.param_lsb == RPN_LSB_MCM &&
        ev.entry_value < MCM_LIMIT) begin
      if (lower_on && ev.chan == LOWER_MASTER) begin
        // Reshape the lower zone, then push the upper zone out of its way.
        upper_sel  = 1'b0;
        lower_last = ev.entry_value[3:0];
        if (lower_last >= LOWER_FULL) begin
          upper_last = UPPER_OFF;
        end else if (lower_last != LOWER_OFF && upper_last <= lower_last) begin
          upper_last = lower_last + 4'd1;
        end
      end else if (upper_on && ev.chan == UPPER_MASTER) begin
        // Reshape the upper zone, then push the lower zone out of its way.
        upper_sel  = 1'b1;
        upper_last = UPPER_OFF - ev.entry_value[3:0];
        if (upper_last <= UPPER_FULL) begin
          lower_last = LOWER_OFF;
        end else if (upper_last <= LOWER_FULL && lower_last >= upper_last) begin
          lower_last = upper_last - 4'd1;
        end
      end else begin
        return 0;
      end
      if (ev.entry_value == '0) return 0;
      target = upper_sel ? TARGET_UPPER : TARGET_LOWER;
      zone_range[{upper_sel, KIND_MAIN}]   = MAIN_DEFAULT;
      zone_range[{upper_sel, KIND_MEMBER}] = MEMBER_DEFAULT;
      r0.report_target = target;
      r0.report_kind   = KIND_MAIN;
      r0.report_range  = MAIN_DEFAULT;
      r0.last_of_run   = 1'b0;
      r1.report_target = target;
      r1.report_kind   = KIND_MEMBER;
      r1.report_range  = MEMBER_DEFAULT;
      r1.last_of_run   = 1'b1;
      return 2;
    end
    return 0;
  endfunction

  function automatic entry_row_t make_row(input int ch, input int msb, input int lsb,
                                          input int val, input int n_typed,
                                          input int tgt, input logic kind);
    entry_row_t row;
    row.ev.chan              = ch[3:0];
    row.ev.param_msb         = msb[6:0];
    row.ev.param_lsb         = lsb[6:0];
    row.ev.entry_value       = val[6:0];
    row.n_typed              = n_typed;
    row.rep.report_target    = tgt[4:0];
    row.rep.report_kind      = kind;
    row.rep.report_range     = val[6:0];
    row.rep.last_of_run      = 1'b1;
    return row;
  endfunction

  // Present one event, wait for its transaction and record what it should cause.
  task automatic send_event(input mzrt_in_t ev, input int n_typed, input mzrt_out_t typed_rep,
                            output int n_pred);
    mzrt_out_t r0;
    mzrt_out_t r1;
    while (!no_gaps && $urandom_range(0, 99) < 28) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= ev;
    do @(posedge clk); while (!item_ready);
    n_pred = apply_data_entry(ev, r0, r1);
    if (n_typed < 0) begin
      if (n_pred > 0) pending_reports.push_back(r0);
      if (n_pred > 1) pending_reports.push_back(r1);
    end else if (n_typed > 0) begin
      pending_reports.push_back(typed_rep);
    end
    events_sent++;
  endtask

  // Hold the sender off until every outstanding report has come back.
  task automatic drain_reports();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [6:0] exp_val,
                             input logic [6:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // The receiver stalls at random, except during the gap-free stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= no_gaps || ($urandom_range(0, 99) >= 28);
    end
  end

  // Compare each report transaction with the oldest expected report.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none, actual %h", $time, result);
      end else begin
        want = pending_reports.pop_front();
        check_field("report_target", 7'(want.report_target), 7'(result.report_target));
        check_field("report_kind", 7'(want.report_kind), 7'(result.report_kind));
        check_field("report_range", want.report_range, result.report_range);
        check_field("last_of_run", 7'(want.last_of_run), 7'(result.last_of_run));
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mzrt_in_t  ev;
    mzrt_out_t no_rep;
    int        n;
    int        sel;
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    no_gaps      = 1'b0;
    idle_cycles  = 0;
    events_sent  = 0;
    range_events = 0;
    reports_seen = 0;
    mismatches   = 0;
    no_rep       = '0;

    // Model state after reset: both zones off, default zone ranges.
    lower_last = LOWER_OFF;
    upper_last = UPPER_OFF;
    zone_range[{1'b0, KIND_MAIN}]   = MAIN_DEFAULT;
    zone_range[{1'b0, KIND_MEMBER}] = MEMBER_DEFAULT;
    zone_range[{1'b1, KIND_MAIN}]   = MAIN_DEFAULT;
    zone_range[{1'b1, KIND_MEMBER}] = MEMBER_DEFAULT;
    foreach (chan_range[i]) chan_range[i] = '0;

    // Directed events: bend ranges at the extremes with both zones off, zone
    // configuration on masters, non-masters and out-of-range values, and
    // other parameter numbers.
    directed_rows.push_back(make_row(0, 0, 0, 127, 1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 0, 0, 0, 1, 15, KIND_MAIN));
    directed_rows.push_back(make_row(7, 0, 0, 64, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 0, 6, 5, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 0, 6, 3, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 0, 6, 15, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 0, 6, 0, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 0, 6, 16, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 0, 6, 127, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(5, 0, 6, 4, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 127, 127, 127, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(3, 0, 127, 9, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(9, 127, 0, 1, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 1, 6, 2, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 0, 1, 0, 0, 0, KIND_MAIN));
    directed_rows.push_back(make_row(0, 0, 0, 0, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(1, 0, 0, 48, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(14, 0, 0, 2, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(10, 0, 0, 85, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(5, 0, 0, 42, -1, 0, KIND_MAIN));
    directed_rows.push_back(make_row(15, 0, 0, 127, 1, 15, KIND_MAIN));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].ev, directed_rows[i].n_typed, directed_rows[i].rep, n);
      if (n > 0) range_events++;
    end
    drain_reports();

    // Random events: bend ranges most often, then configuration attempts, then
    // other parameter numbers. Every event counts toward the total.
    while (events_sent < ITEM_GOAL) begin
      no_gaps = (events_sent >= 300 && events_sent < 420);
      if (events_sent == 500) drain_reports();
      sel            = $urandom_range(0, 99);
      ev.chan        = 4'($urandom);
      ev.entry_value = 7'($urandom);
      ev.param_msb   = RPN_MSB_ZERO;
      ev.param_lsb   = RPN_LSB_BEND;
      if (sel >= 50 && sel < 80) begin
        ev.param_lsb = RPN_LSB_MCM;
        if ($urandom_range(0, 99) < 70) ev.chan = $urandom_range(0, 1) ? UPPER_MASTER : LOWER_MASTER;
        if ($urandom_range(0, 99) < 70) ev.entry_value = 7'($urandom_range(0, 15));
      end else if (sel >= 80) begin
        ev.param_msb = 7'($urandom);
        ev.param_lsb = 7'($urandom);
      end
      send_event(ev, -1, no_rep, n);
      if (n > 0) range_events++;
    end
    no_gaps = 1'b0;
    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d data-entry events, %0d of them producing bend range reports.",
             events_sent, range_events);
    $display("Checked %0d reports, %0d field mismatches.", reports_seen, mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
